// ----- sv/spc_pkg.sv -----
// Shared types and constants for the skin pixel classifier.
// Holds the request and response payload structs and the register indexes.
// No dependencies.
package spc_pkg;

   localparam int CHANNEL_WIDTH    = 8;
   localparam int PROB_WIDTH       = 17;
   localparam int ENTRY_WIDTH      = PROB_WIDTH + 1;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int DEFAULT_QUANT_BITS = 3;

   localparam logic KIND_LOAD     = 1'b0;
   localparam logic KIND_CLASSIFY = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROB_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SKIN_WHEN_BELOW = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VALUE_LOW       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VALUE_HIGH      = 3'd3;

   localparam logic [PROB_WIDTH-1:0]    RESET_PROB_THRESHOLD = 17'd26214;
   localparam logic                     RESET_SKIN_WHEN_BELOW = 1'b1;
   localparam logic [CHANNEL_WIDTH-1:0] RESET_VALUE_LOW  = 8'd51;
   localparam logic [CHANNEL_WIDTH-1:0] RESET_VALUE_HIGH = 8'd229;
   localparam logic [CHANNEL_WIDTH-1:0] REJECT_CHANNEL   = 8'd255;

   typedef struct packed {
      logic                     kind;
      logic [CHANNEL_WIDTH-1:0] red;
      logic [CHANNEL_WIDTH-1:0] green;
      logic [CHANNEL_WIDTH-1:0] blue;
      logic [PROB_WIDTH-1:0]    entry_probability;
      logic                     entry_present;
   } req_type;

   typedef struct packed {
      logic [CHANNEL_WIDTH-1:0] out_red;
      logic [CHANNEL_WIDTH-1:0] out_green;
      logic [CHANNEL_WIDTH-1:0] out_blue;
      logic                     found;
      logic                     is_skin;
   } rsp_type;

endpackage

// ----- sv/skin_pixel_classifier.sv -----
// Skin pixel classifier: color table lookup followed by HSV range tests.
// Stage 1 registers the request and its table read; the output registers follow.
// Throughput: one request per cycle unless busy, set by the single table read port.
// Load requests write the table and give no response; classify requests give one.
// Reset is synchronous; afterwards busy stays high while all 2**(3*(8-QUANT_BITS))
// table entries (32768 by default) are cleared; register writes are taken meanwhile.
module skin_pixel_classifier
   import spc_pkg::*;
#(
   parameter int QUANT_BITS = DEFAULT_QUANT_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [PROB_WIDTH-1:0]      csr_data
);

   localparam int KEY_BITS    = CHANNEL_WIDTH - QUANT_BITS;
   localparam int INDEX_BITS  = 3 * KEY_BITS;
   localparam int TABLE_DEPTH = 1 << INDEX_BITS;

   logic [ENTRY_WIDTH-1:0]   table_mem [TABLE_DEPTH];
   logic [ENTRY_WIDTH-1:0]   entry_ff;

   logic                     clear_active_ff, clear_active_in;
   logic [INDEX_BITS-1:0]    clear_idx_ff, clear_idx_in;

   logic [PROB_WIDTH-1:0]    prob_threshold_ff, prob_threshold_in;
   logic                     skin_when_below_ff, skin_when_below_in;
   logic [CHANNEL_WIDTH-1:0] value_low_ff, value_low_in;
   logic [CHANNEL_WIDTH-1:0] value_high_ff, value_high_in;

   logic                     s1_valid_ff, s1_valid_in;
   req_type                  s1_req_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic                     csr_write;
   logic [INDEX_BITS-1:0]    req_index;
   logic                     mem_we;
   logic [INDEX_BITS-1:0]    mem_waddr;
   logic [ENTRY_WIDTH-1:0]   mem_wdata;

   assign busy      = clear_active_ff;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign csr_write = csr_valid && csr_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_index = {req_data.red[CHANNEL_WIDTH-1 -: KEY_BITS],
                       req_data.green[CHANNEL_WIDTH-1 -: KEY_BITS],
                       req_data.blue[CHANNEL_WIDTH-1 -: KEY_BITS]};

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = req_index;
      mem_wdata = {req_data.entry_present, req_data.entry_probability};
      if (clear_active_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_idx_ff;
         mem_wdata = '0;
      end else if (accept && req_data.kind == KIND_LOAD) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      entry_ff <= table_mem[req_index];
   end

   always_comb begin
      clear_active_in = clear_active_ff;
      clear_idx_in    = clear_idx_ff;
      if (clear_active_ff) begin
         clear_idx_in = clear_idx_ff + 1'b1;
         if (clear_idx_ff == {INDEX_BITS{1'b1}}) begin
            clear_active_in = 1'b0;
         end
      end
   end

   always_comb begin
      prob_threshold_in  = prob_threshold_ff;
      skin_when_below_in = skin_when_below_ff;
      value_low_in       = value_low_ff;
      value_high_in      = value_high_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PROB_THRESHOLD:  prob_threshold_in  = csr_data;
            CSR_SKIN_WHEN_BELOW: skin_when_below_in = csr_data[0];
            CSR_VALUE_LOW:       value_low_in       = csr_data[CHANNEL_WIDTH-1:0];
            CSR_VALUE_HIGH:      value_high_in      = csr_data[CHANNEL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign s1_valid_in = accept && req_data.kind == KIND_CLASSIFY;

   always_comb begin
      logic [CHANNEL_WIDTH-1:0] mx;
      logic [CHANNEL_WIDTH-1:0] mn;
      logic [CHANNEL_WIDTH-1:0] d;
      logic [CHANNEL_WIDTH-1:0] gb;
      logic [11:0]              d10;
      logic [11:0]              d5;
      logic [11:0]              mx3;
      logic [11:0]              gb6;
      logic [PROB_WIDTH-1:0]    p;
      logic                     prob_ok;
      logic                     hsv_ok;
      logic                     keep;
      mx = s1_req_ff.red;
      if (s1_req_ff.green > mx) mx = s1_req_ff.green;
      if (s1_req_ff.blue > mx) mx = s1_req_ff.blue;
      mn = s1_req_ff.red;
      if (s1_req_ff.green < mn) mn = s1_req_ff.green;
      if (s1_req_ff.blue < mn) mn = s1_req_ff.blue;
      d   = mx - mn;
      gb  = s1_req_ff.green - s1_req_ff.blue;
      d10 = {4'd0, d} * 12'd10;
      d5  = {4'd0, d} * 12'd5;
      mx3 = {4'd0, mx} * 12'd3;
      gb6 = {4'd0, gb} * 12'd6;
      p   = entry_ff[PROB_WIDTH-1:0];
      prob_ok = skin_when_below_ff ? (p <= prob_threshold_ff) : (p >= prob_threshold_ff);
      hsv_ok  = (d != '0) && (d10 >= {4'd0, mx}) && (d5 <= mx3)
                && (mx >= value_low_ff) && (mx <= value_high_ff)
                && (s1_req_ff.red == mx) && (s1_req_ff.green >= s1_req_ff.blue)
                && (gb6 <= d5);
      keep = prob_ok && hsv_ok;
      rsp_data_in.found = entry_ff[PROB_WIDTH];
      if (!entry_ff[PROB_WIDTH] || keep) begin
         rsp_data_in.out_red   = s1_req_ff.red;
         rsp_data_in.out_green = s1_req_ff.green;
         rsp_data_in.out_blue  = s1_req_ff.blue;
         rsp_data_in.is_skin   = 1'b1;
      end else begin
         rsp_data_in.out_red   = REJECT_CHANNEL;
         rsp_data_in.out_green = REJECT_CHANNEL;
         rsp_data_in.out_blue  = REJECT_CHANNEL;
         rsp_data_in.is_skin   = 1'b0;
      end
   end

   assign rsp_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff    <= 1'b1;
         clear_idx_ff       <= '0;
         prob_threshold_ff  <= RESET_PROB_THRESHOLD;
         skin_when_below_ff <= RESET_SKIN_WHEN_BELOW;
         value_low_ff       <= RESET_VALUE_LOW;
         value_high_ff      <= RESET_VALUE_HIGH;
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         clear_active_ff    <= clear_active_in;
         clear_idx_ff       <= clear_idx_in;
         prob_threshold_ff  <= prob_threshold_in;
         skin_when_below_ff <= skin_when_below_in;
         value_low_ff       <= value_low_in;
         value_high_ff      <= value_high_in;
         s1_valid_ff        <= s1_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff   <= req_data;
      rsp_data_ff <= rsp_data_in;
   end

   // A response only follows a classify request that was registered in stage 1.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(s1_valid_ff) && s1_valid_ff == $past(s1_valid_in))
      else $error("response without a matching classify request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.is_skin)
      else $error("absent color was not passed through");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_skin |->
         rsp_data.out_red == REJECT_CHANNEL && rsp_data.out_green == REJECT_CHANNEL
         && rsp_data.out_blue == REJECT_CHANNEL)
      else $error("rejected pixel is not white");

   assert property (@(posedge clock) $past(reset) |-> busy && clear_idx_ff == '0)
      else $error("table clear did not restart after reset");

endmodule

// ----- test/spc_checker.sv -----
// Response checker for the skin pixel classifier testbench.
// Watches the request, response and register channels, predicts each classify
// response from its own copy of the color table and registers; depends on spc_pkg.
`timescale 1ns / 100ps

module spc_checker
   import spc_pkg::*;
#(
   parameter int QUANT_BITS = DEFAULT_QUANT_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  req_type                    req_data,
   input  logic                       rsp_valid,
   input  rsp_type                    rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [PROB_WIDTH-1:0]      csr_data,
   output int                         fail_count,
   output int                         pending_count
);

   localparam int KEY_BITS    = CHANNEL_WIDTH - QUANT_BITS;
   localparam int TABLE_DEPTH = 1 << (3 * KEY_BITS);

   logic [ENTRY_WIDTH-1:0]   color_table [TABLE_DEPTH];
   logic [PROB_WIDTH-1:0]    threshold;
   logic                     skin_below;
   logic [CHANNEL_WIDTH-1:0] bright_low;
   logic [CHANNEL_WIDTH-1:0] bright_high;
   rsp_type                  expected_pixels [$];
   int                       mismatch_total = 0;

   function automatic int unsigned bucket_index(input req_type rq);
      int unsigned qr, qg, qb;
      qr = int'(rq.red) >> QUANT_BITS;
      qg = int'(rq.green) >> QUANT_BITS;
      qb = int'(rq.blue) >> QUANT_BITS;
      return ((qr << (2 * KEY_BITS)) | (qg << KEY_BITS) | qb) % TABLE_DEPTH;
   endfunction

   function automatic bit hsv_in_range(input req_type rq);
      int unsigned r, g, b, mx, mn, d;
      r = 32'(rq.red);
      g = 32'(rq.green);
      b = 32'(rq.blue);
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      if (d == 0) return 1'b0;
      if (10 * d < mx || 5 * d > 3 * mx) return 1'b0;
      if (mx < bright_low || mx > bright_high) return 1'b0;
      if (r != mx || g < b) return 1'b0;
      return 6 * (g - b) <= 5 * d;
   endfunction

   function automatic rsp_type classify_pixel(input req_type rq);
      logic [ENTRY_WIDTH-1:0] entry;
      logic [PROB_WIDTH-1:0]  prob;
      rsp_type                res;
      bit                     keep;
      entry = color_table[bucket_index(rq)];
      prob = entry[PROB_WIDTH-1:0];
      res.out_red = rq.red;
      res.out_green = rq.green;
      res.out_blue = rq.blue;
      if (!entry[PROB_WIDTH]) begin
         res.found = 1'b0;
         res.is_skin = 1'b1;
         return res;
      end
      keep = (skin_below ? (prob <= threshold) : (prob >= threshold)) && hsv_in_range(rq);
      if (!keep) begin
         res.out_red = REJECT_CHANNEL;
         res.out_green = REJECT_CHANNEL;
         res.out_blue = REJECT_CHANNEL;
      end
      res.found = 1'b1;
      res.is_skin = keep;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) color_table[i] = '0;
         threshold = RESET_PROB_THRESHOLD;
         skin_below = RESET_SKIN_WHEN_BELOW;
         bright_low = RESET_VALUE_LOW;
         bright_high = RESET_VALUE_HIGH;
         expected_pixels.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               if (mismatch_total < 10)
                  $display("Unexpected response: r=%0d g=%0d b=%0d found=%0d skin=%0d",
                           rsp_data.out_red, rsp_data.out_green, rsp_data.out_blue,
                           rsp_data.found, rsp_data.is_skin);
               mismatch_total++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.out_red !== want.out_red || rsp_data.out_green !== want.out_green ||
                   rsp_data.out_blue !== want.out_blue || rsp_data.found !== want.found ||
                   rsp_data.is_skin !== want.is_skin) begin
                  if (mismatch_total < 10)
                     $display({"Response mismatch: expected r=%0d g=%0d b=%0d found=%0d ",
                               "skin=%0d, got r=%0d g=%0d b=%0d found=%0d skin=%0d"},
                              want.out_red, want.out_green, want.out_blue, want.found,
                              want.is_skin, rsp_data.out_red, rsp_data.out_green,
                              rsp_data.out_blue, rsp_data.found, rsp_data.is_skin);
                  mismatch_total++;
               end
            end
         end
         if (start && !busy) begin
            if (req_data.kind == KIND_LOAD)
               color_table[bucket_index(req_data)] = {req_data.entry_present,
                                                      req_data.entry_probability};
            else
               expected_pixels.push_back(classify_pixel(req_data));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PROB_THRESHOLD: threshold = csr_data;
               CSR_SKIN_WHEN_BELOW: skin_below = csr_data[0];
               CSR_VALUE_LOW: bright_low = csr_data[CHANNEL_WIDTH-1:0];
               CSR_VALUE_HIGH: bright_high = csr_data[CHANNEL_WIDTH-1:0];
               default: ;
            endcase
         end
      end
      fail_count <= mismatch_total;
      pending_count <= expected_pixels.size();
   end

endmodule

// ----- test/tb_skin_pixel_classifier.sv -----
// Top of the skin pixel classifier testbench: clock, reset, requests and register writes.
// Drives directed and random load and classify requests; spc_checker does the comparing.
// Depends on spc_pkg, skin_pixel_classifier and spc_checker.
`timescale 1ns / 100ps

module tb_skin_pixel_classifier;
   import spc_pkg::*;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       start;
   logic                       busy;
   req_type                    req_data;
   logic                       rsp_valid;
   rsp_type                    rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [PROB_WIDTH-1:0]      csr_data;
   int                         fail_count;
   int                         pending_count;

   int unsigned                burst_left = 0;
   int                         load_count = 0;
   int                         classify_count = 0;
   int                         setting_count = 0;
   logic [PROB_WIDTH-1:0]      cur_threshold;
   logic [23:0]                key_pool [$];

   skin_pixel_classifier i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   spc_checker i_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic issue_request(input req_type rq);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (rq.kind == KIND_LOAD) load_count++;
      else classify_count++;
   endtask

   task automatic load_entry(input logic [23:0] color, input logic [PROB_WIDTH-1:0] prob,
                             input logic present);
      req_type rq;
      rq.kind = KIND_LOAD;
      {rq.red, rq.green, rq.blue} = color;
      rq.entry_probability = prob;
      rq.entry_present = present;
      issue_request(rq);
   endtask

   task automatic classify_color(input logic [23:0] color);
      req_type rq;
      rq.kind = KIND_CLASSIFY;
      {rq.red, rq.green, rq.blue} = color;
      rq.entry_probability = PROB_WIDTH'($urandom);
      rq.entry_present = 1'($urandom_range(0, 1));
      issue_request(rq);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [PROB_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [PROB_WIDTH-1:0] thr, input logic below,
                                input logic [CHANNEL_WIDTH-1:0] lo,
                                input logic [CHANNEL_WIDTH-1:0] hi);
      drain_results();
      write_register(CSR_PROB_THRESHOLD, thr);
      write_register(CSR_SKIN_WHEN_BELOW, {16'($urandom), below});
      write_register(CSR_VALUE_LOW, {9'($urandom), lo});
      write_register(CSR_VALUE_HIGH, {9'($urandom), hi});
      write_register(CSR_VALUE_HIGH + CSR_INDEX_WIDTH'($urandom_range(1, 4)),
                     PROB_WIDTH'($urandom));
      csr_valid <= 1'b0;
      cur_threshold = thr;
      setting_count++;
   endtask

   function automatic logic [23:0] skin_like_color();
      int unsigned mx, d, b, g;
      mx = $urandom_range(20, 255);
      d = $urandom_range((mx + 9) / 10, (3 * mx) / 5);
      b = mx - d;
      g = b + $urandom_range(0, (5 * d) / 6);
      return {8'(mx), 8'(g), 8'(b)};
   endfunction

   function automatic logic [PROB_WIDTH-1:0] pick_probability();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 17'd65536;
         2: return '1;
         3: return cur_threshold;
         4: return (cur_threshold == '0) ? cur_threshold : cur_threshold - 1'b1;
         5: return (cur_threshold == '1) ? cur_threshold : cur_threshold + 1'b1;
         6: return PROB_WIDTH'($urandom_range(0, 65536));
         default: return PROB_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] pool_color(input bit exact);
      logic [23:0] color;
      color = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (!exact) color = color ^ (24'($urandom) & 24'h070707);
      return color;
   endfunction

   // Mostly loads and lookups that land on loaded buckets, with skin-like colors
   // so that the hue, saturation and value tests are reached, plus some noise.
   task automatic random_request();
      logic [23:0] color;
      int unsigned sel;
      logic [7:0]  level;
      if ($urandom_range(0, 99) < 35) begin
         sel = $urandom_range(0, 9);
         if (sel < 4 && key_pool.size() != 0) color = pool_color(1'b0);
         else if (sel < 8) color = skin_like_color();
         else color = 24'($urandom);
         load_entry(color, pick_probability(), $urandom_range(0, 7) != 0);
         if (key_pool.size() >= 32) void'(key_pool.pop_front());
         key_pool.push_back(color);
      end else begin
         sel = $urandom_range(0, 19);
         if (sel < 12 && key_pool.size() != 0) color = pool_color(sel < 4);
         else if (sel < 16) color = skin_like_color();
         else if (sel < 17) begin
            level = 8'($urandom);
            color = {level, level, level};
         end else color = 24'($urandom);
         classify_color(color);
      end
   endtask

   task automatic run_phase(input logic [PROB_WIDTH-1:0] thr, input logic below,
                            input logic [CHANNEL_WIDTH-1:0] lo,
                            input logic [CHANNEL_WIDTH-1:0] hi, input int count);
      apply_setting(thr, below, lo, hi);
      repeat (count) begin
         if ($urandom_range(0, 59) == 0) drain_results();
         random_request();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      apply_setting(RESET_PROB_THRESHOLD, RESET_SKIN_WHEN_BELOW, RESET_VALUE_LOW,
                    RESET_VALUE_HIGH);

      classify_color({8'd0, 8'd0, 8'd0});
      classify_color({8'd255, 8'd255, 8'd255});
      load_entry({8'd200, 8'd120, 8'd90}, 17'd1000, 1'b1);
      classify_color({8'd200, 8'd120, 8'd90});
      classify_color({8'd205, 8'd125, 8'd95});
      classify_color({8'd207, 8'd127, 8'd94});
      load_entry({8'd128, 8'd128, 8'd128}, 17'd0, 1'b1);
      classify_color({8'd130, 8'd130, 8'd130});
      load_entry({8'd200, 8'd120, 8'd90}, 17'd131071, 1'b1);
      classify_color({8'd200, 8'd120, 8'd90});
      load_entry({8'd200, 8'd120, 8'd90}, RESET_PROB_THRESHOLD, 1'b1);
      classify_color({8'd200, 8'd120, 8'd90});
      load_entry({8'd200, 8'd120, 8'd90}, RESET_PROB_THRESHOLD + 1'b1, 1'b1);
      classify_color({8'd200, 8'd120, 8'd90});
      load_entry({8'd200, 8'd120, 8'd90}, 17'd5, 1'b0);
      classify_color({8'd200, 8'd120, 8'd90});
      load_entry({8'd255, 8'd0, 8'd0}, 17'd65536, 1'b1);
      classify_color({8'd255, 8'd0, 8'd0});
      load_entry({8'd100, 8'd200, 8'd50}, 17'd0, 1'b1);
      classify_color({8'd100, 8'd200, 8'd50});
      load_entry({8'd200, 8'd90, 8'd120}, 17'd0, 1'b1);
      classify_color({8'd200, 8'd90, 8'd120});
      load_entry({8'd240, 8'd150, 8'd100}, 17'd0, 1'b1);
      classify_color({8'd240, 8'd150, 8'd100});
      classify_color({8'd7, 8'd7, 8'd7});

      run_phase(RESET_PROB_THRESHOLD, RESET_SKIN_WHEN_BELOW, RESET_VALUE_LOW,
                RESET_VALUE_HIGH, 75);
      run_phase(17'd65536, 1'b1, 8'd0, 8'd255, 75);
      run_phase(17'd0, 1'b0, 8'd0, 8'd255, 75);
      run_phase(17'd131071, 1'b0, 8'd255, 8'd0, 75);
      run_phase(PROB_WIDTH'($urandom), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 120)),
                8'($urandom_range(130, 255)), 75);
      run_phase(17'd131071, 1'b1, 8'd255, 8'd255, 75);
      run_phase(17'd0, 1'b1, 8'd0, 8'd0, 75);

      drain_results();
      repeat (8) @(posedge clock);
      $display("Covered %0d load and %0d classify requests over %0d register settings.",
               load_count, classify_count, setting_count);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out waiting for the classifier.");
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- files.f -----
sv/spc_pkg.sv
sv/skin_pixel_classifier.sv
test/spc_checker.sv
test/tb_skin_pixel_classifier.sv
